[sv/pse_pkg.sv]
package pse_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int WORD_W      = 32;

   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_STAR  = 8'd42;
   localparam logic [7:0] CH_SLASH = 8'd47;
   localparam logic [7:0] CH_PCT   = 8'd37;

   localparam logic [WORD_W-1:0] EMPTY_POP = '1;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last_symbol;
   } req_payload_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] value;
      logic                     underflow;
      logic                     overflow;
      logic                     divide_by_zero;
   } rsp_payload_type;

   typedef struct packed {
      logic underflow;
      logic overflow;
      logic divide_by_zero;
   } flags_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] quotient;
      logic [WORD_W-1:0] remainder;
   } div_rsp_type;

endpackage

[sv/pse_divider.sv]
module pse_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  pse_pkg::div_req_type  div_req,
   output pse_pkg::div_rsp_type  div_rsp
);

   localparam int W  = pse_pkg::WORD_W;
   localparam int SW = $clog2(W);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [SW-1:0] step_ff, step_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;
   logic [W+1:0]  diff;

   // one quotient bit per cycle, restoring form
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = {1'b0, shifted} - {2'b00, dvs_ff};
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[W+1]) begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end else begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[sv/postfix_stack_evaluator.sv]
// Postfix expression evaluator on a stack of 32-bit values.
// Input channel req_: one expression character per transfer, with
// last_symbol marking the end of the expression. Result channel rsp_:
// one transfer per expression, carrying the final popped value and the
// sticky underflow, overflow and divide-by-zero flags.
// Each character is handled in full before the next is taken: an
// operand is pushed; + - * pop two values, compute and push; / and %
// with a nonzero divisor also wait on the shared divider, which
// resolves one quotient bit per cycle. A last character adds a final
// pop, after which the result is registered. The stack sits in a
// memory with one write port and one registered read port, so every
// pop has an addressing state and a capturing state.
// The result waits in an output register; the block keeps accepting
// characters while the receiver stalls and holds only when a second
// result is ready before the first has been taken.
// Reset empties the stack, clears the flags and drops any held result;
// no clearing pass over the memory is needed.
module postfix_stack_evaluator #(
   parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  pse_pkg::req_payload_type  req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pse_pkg::rsp_payload_type  rsp_data
);

   localparam int W  = pse_pkg::WORD_W;
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_POPA = 10'b0000000010,
      S_GETA = 10'b0000000100,
      S_POPB = 10'b0000001000,
      S_GETB = 10'b0000010000,
      S_EXEC = 10'b0000100000,
      S_DIV  = 10'b0001000000,
      S_PUSH = 10'b0010000000,
      S_POPF = 10'b0100000000,
      S_GETF = 10'b1000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   pse_pkg::flags_type   flags_ff, flags_in;
   logic                 out_valid_ff, out_valid_in;
   pse_pkg::rsp_payload_type out_ff, out_in;

   logic [7:0]   sym_ff, sym_in;
   logic         last_ff, last_in;
   logic [W-1:0] opa_ff, opa_in;
   logic [W-1:0] opb_ff, opb_in;
   logic [W-1:0] res_ff, res_in;
   logic         neg_a_ff, neg_a_in;
   logic         neg_b_ff, neg_b_in;

   logic [W-1:0] stack_mem [STACK_DEPTH];
   logic [W-1:0] rd_data_ff;
   logic [AW-1:0] rd_idx;
   logic [AW-1:0] wr_idx;
   logic         wr_en;
   logic         stack_empty;
   logic         stack_full;
   logic         is_op;
   logic         req_take;

   pse_pkg::div_req_type div_req;
   pse_pkg::div_rsp_type div_rsp;

   assign stack_empty = (count_ff == '0);
   assign stack_full  = (count_ff >= CW'(STACK_DEPTH));
   assign rd_idx      = stack_empty ? '0 : AW'(count_ff - 1'b1);
   assign wr_idx      = AW'(count_ff);
   assign wr_en       = (state_ff == S_PUSH) && !stack_full;

   assign is_op = (req_data.symbol == pse_pkg::CH_PLUS)  ||
                  (req_data.symbol == pse_pkg::CH_MINUS) ||
                  (req_data.symbol == pse_pkg::CH_STAR)  ||
                  (req_data.symbol == pse_pkg::CH_SLASH) ||
                  (req_data.symbol == pse_pkg::CH_PCT);

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_idx] <= res_ff;
      end
      rd_data_ff <= stack_mem[rd_idx];
   end

   pse_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      flags_in     = flags_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      res_in       = res_ff;
      neg_a_in     = neg_a_ff;
      neg_b_in     = neg_b_ff;
      div_req      = '0;

      // drop the held result once the receiver takes it
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               sym_in  = req_data.symbol;
               last_in = req_data.last_symbol;
               res_in  = W'(req_data.symbol) - W'(pse_pkg::CH_ZERO);
               state_in = is_op ? S_POPA : S_PUSH;
            end
         end
         S_POPA: state_in = S_GETA;
         S_GETA: begin
            if (stack_empty) begin
               opa_in = pse_pkg::EMPTY_POP;
               flags_in.underflow = 1'b1;
            end else begin
               opa_in   = rd_data_ff;
               count_in = count_ff - 1'b1;
            end
            state_in = S_POPB;
         end
         S_POPB: state_in = S_GETB;
         S_GETB: begin
            if (stack_empty) begin
               opb_in = pse_pkg::EMPTY_POP;
               flags_in.underflow = 1'b1;
            end else begin
               opb_in   = rd_data_ff;
               count_in = count_ff - 1'b1;
            end
            state_in = S_EXEC;
         end
         S_EXEC: begin
            neg_a_in = opa_ff[W-1];
            neg_b_in = opb_ff[W-1];
            state_in = S_PUSH;
            case (sym_ff)
               pse_pkg::CH_PLUS:  res_in = opb_ff + opa_ff;
               pse_pkg::CH_MINUS: res_in = opb_ff - opa_ff;
               pse_pkg::CH_STAR:  res_in = W'(opb_ff * opa_ff);
               default: begin
                  if (opa_ff == '0) begin
                     res_in = '0;
                     flags_in.divide_by_zero = 1'b1;
                  end else begin
                     div_req.start    = 1'b1;
                     div_req.dividend = opb_ff[W-1] ? (W'(0) - opb_ff) : opb_ff;
                     div_req.divisor  = opa_ff[W-1] ? (W'(0) - opa_ff) : opa_ff;
                     state_in = S_DIV;
                  end
               end
            endcase
         end
         S_DIV: begin
            if (div_rsp.done) begin
               if (sym_ff == pse_pkg::CH_SLASH) begin
                  res_in = (neg_a_ff ^ neg_b_ff) ?
                           (W'(0) - div_rsp.quotient) : div_rsp.quotient;
               end else begin
                  res_in = neg_b_ff ? (W'(0) - div_rsp.remainder) : div_rsp.remainder;
               end
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (stack_full) begin
               flags_in.overflow = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
            state_in = last_ff ? S_POPF : S_IDLE;
         end
         S_POPF: state_in = S_GETF;
         S_GETF: begin
            // hold until the previous result has gone
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in          = 1'b1;
               out_in.value          = stack_empty ? pse_pkg::EMPTY_POP : rd_data_ff;
               out_in.underflow      = flags_ff.underflow | stack_empty;
               out_in.overflow       = flags_ff.overflow;
               out_in.divide_by_zero = flags_ff.divide_by_zero;
               count_in = '0;
               flags_in = '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         flags_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      sym_ff   <= sym_in;
      last_ff  <= last_in;
      opa_ff   <= opa_in;
      opb_ff   <= opb_in;
      res_ff   <= res_in;
      neg_a_ff <= neg_a_in;
      neg_b_ff <= neg_b_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
